// ===== hw/rtl/srlc_pkg.sv =====
// Shared types and constants of the two-region LRU sector cache.
`timescale 1ns / 1ps
`default_nettype none
package srlc_pkg;
  localparam int SectorW      = 12;
  localparam int BlockSectors = 8;
  localparam int OffW         = 3;
  localparam int CntW         = 4;
  localparam int AgeW         = 5;
  localparam int DefFatSlots  = 4;
  localparam int DefDataSlots = 8;
  localparam logic [SectorW-1:0] ImageReset = 12'd2880;
  localparam logic [SectorW-1:0] FatReset   = 12'd33;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    KIND_GRANT = 3'd0,
    KIND_WB    = 3'd1,
    KIND_FILL  = 3'd2,
    KIND_INV   = 3'd3,
    KIND_CLR   = 3'd4
  } kind_e;

  typedef enum logic {
    REG_IMAGE = 1'b0,
    REG_FAT   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic               clr;
    logic               touch;
    logic               sel;
    logic               load;
    logic               set_dirty;
    logic               sel_valid;
    logic [AgeW-1:0]    sel_age;
    logic [AgeW-1:0]    nmax;
    logic [SectorW-1:0] new_tag;
    logic               new_dirty;
  } cell_cmd_t;

  typedef struct packed {
    logic               valid;
    logic               dirty;
    logic [SectorW-1:0] tag;
    logic [AgeW-1:0]    age;
  } cell_st_t;
endpackage
`default_nettype wire

// ===== hw/rtl/srlc_cell.sv =====
// One cache slot: tag, valid, dirty and recency rank.
`timescale 1ns / 1ps
`default_nettype none
module srlc_cell
  import srlc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cell_cmd_t cmd_i,
  output cell_st_t       st_o
);
  cell_st_t st_q, st_d;

  always_comb begin
    st_d = st_q;
    if (cmd_i.clr) begin
      st_d = '0;
    end else begin
      if (cmd_i.touch) begin
        if (cmd_i.sel) begin
          st_d.age = '0;
        end else if (st_q.valid && (!cmd_i.sel_valid || st_q.age < cmd_i.sel_age)
                     && st_q.age < cmd_i.nmax) begin
          st_d.age = st_q.age + AgeW'(1);
        end
      end
      if (cmd_i.sel && cmd_i.load) begin
        st_d.tag   = cmd_i.new_tag;
        st_d.valid = 1'b1;
        st_d.dirty = cmd_i.new_dirty;
      end
      if (cmd_i.sel && cmd_i.set_dirty) begin
        st_d.dirty = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;
endmodule
`default_nettype wire

// ===== hw/rtl/two_region_lru_sector_cache_unit.sv =====
// Top level: slot row and lookup/replacement sequencer.
// channel  dir  tdata                      tuser         tlast
// s_axis   in   sector                     action        -
// m_axis   out  region..misses_total       kind          last_of_run
// cfg      in   we/index/data, no handshake
// An accepted beat starts a scan of its region, one slot per cycle (at most 8
// with the defaults); a hit then goes on to its grant, a miss to the write-back
// check, the fill and the grant, waiting while the output is held.
// A flush walks all slots one per cycle, held while a write-back waits, then clears.
// A result waits in the output register while m_axis_tready is low;
// the sequencer stalls only when it has a further result to place.
// Reset empties every slot and clears counters; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module two_region_lru_sector_cache_unit
  import srlc_pkg::*;
#(
  parameter int FAT_SLOTS  = DefFatSlots,
  parameter int DATA_SLOTS = DefDataSlots
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_index_i,
  input  wire logic [SectorW-1:0] cfg_data_i,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [15:0]        s_axis_tdata,  // sector, zero pad
  input  wire logic [1:0]         s_axis_tuser,  // action
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [87:0]             m_axis_tdata,  // region,slot,base,offset,count,hit,hits,misses
  output logic [2:0]              m_axis_tuser,  // kind
  output logic                    m_axis_tlast
);
  localparam int NC = FAT_SLOTS + DATA_SLOTS;
  localparam int CW = (NC > 1) ? $clog2(NC) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_HIT, S_WB, S_FILL, S_GNT, S_FLUSH, S_CLR, S_INV
  } state_e;

  state_e             st_q;
  action_e            act_q;
  logic [SectorW-1:0] sec_q;
  logic [CW-1:0]      idx_q, inv_q, vic_q;
  logic               inv_ok_q, fat_q;
  logic [AgeW-1:0]    vage_q;
  logic [31:0]        hits_q, miss_q;
  logic [SectorW-1:0] img_q, fatlim_q;

  logic               ov_q, olast_q, oreg_q, ohit_q;
  kind_e              okind_q;
  logic [2:0]         oslot_q, ooff_q;
  logic [SectorW-1:0] obs_q;
  logic [CntW-1:0]    ocnt_q;
  logic [31:0]        ohits_q, omiss_q;

  cell_cmd_t cmd [NC];
  cell_st_t  cst [NC];
  cell_st_t  cur;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    srlc_cell u_cell (.clk_i, .rst_ni, .cmd_i(cmd[i]), .st_o(cst[i]));
  end

  assign cur = cst[idx_q];

  logic [CW-1:0]      lo, last;
  logic [SectorW-1:0] start;
  logic               can_emit, do_touch, do_load, do_dirty, do_clr, o_load;
  logic [31:0]        slot32;

  assign lo     = fat_q ? CW'(0) : CW'(FAT_SLOTS);
  assign last   = fat_q ? CW'(FAT_SLOTS - 1) : CW'(NC - 1);
  assign start  = sec_q & ~SectorW'(BlockSectors - 1);
  assign can_emit = !ov_q || m_axis_tready;
  assign slot32 = 32'(idx_q) - 32'(lo);

  function automatic logic [CntW-1:0] span(input logic [SectorW-1:0] s,
                                           input logic [SectorW-1:0] img);
    logic [SectorW-1:0] d;
    d = img - s;
    if (s >= img) return '0;
    else if (d < SectorW'(BlockSectors)) return CntW'(d);
    else return CntW'(BlockSectors);
  endfunction

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      cmd[i].clr       = do_clr;
      cmd[i].touch     = do_touch && ((i < FAT_SLOTS) == fat_q);
      cmd[i].sel       = (CW'(i) == idx_q);
      cmd[i].load      = do_load;
      cmd[i].set_dirty = do_dirty;
      cmd[i].sel_valid = cur.valid;
      cmd[i].sel_age   = cur.age;
      cmd[i].nmax      = (i < FAT_SLOTS) ? AgeW'(FAT_SLOTS - 1) : AgeW'(DATA_SLOTS - 1);
      cmd[i].new_tag   = start;
      cmd[i].new_dirty = (act_q == ACT_WRITE);
    end
  end

  always_comb begin
    do_touch = 1'b0;
    do_load  = 1'b0;
    do_dirty = 1'b0;
    do_clr   = 1'b0;
    o_load   = 1'b0;
    case (st_q)
      S_HIT: begin
        do_touch = can_emit;
        do_dirty = can_emit && (act_q == ACT_WRITE);
        o_load   = can_emit;
      end
      S_GNT: begin
        do_touch = can_emit;
        do_load  = can_emit;
        o_load   = can_emit;
      end
      S_CLR: begin
        do_clr = can_emit;
        o_load = can_emit;
      end
      S_WB, S_FLUSH: o_load = can_emit && cur.valid && cur.dirty;
      S_FILL, S_INV: o_load = can_emit;
      default: ;
    endcase
  end

  assign s_axis_tready = (st_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      act_q    <= ACT_READ;
      sec_q    <= '0;
      idx_q    <= '0;
      inv_q    <= '0;
      vic_q    <= '0;
      inv_ok_q <= 1'b0;
      fat_q    <= 1'b0;
      vage_q   <= '0;
      hits_q   <= '0;
      miss_q   <= '0;
      img_q    <= ImageReset;
      fatlim_q <= FatReset;
      ov_q     <= 1'b0;
      olast_q  <= 1'b0;
      okind_q  <= KIND_GRANT;
      oreg_q   <= 1'b0;
      oslot_q  <= '0;
      obs_q    <= '0;
      ooff_q   <= '0;
      ocnt_q   <= '0;
      ohit_q   <= 1'b0;
      ohits_q  <= '0;
      omiss_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_IMAGE) img_q <= cfg_data_i;
        else fatlim_q <= cfg_data_i;
      end
      ov_q <= o_load || (ov_q && !m_axis_tready);
      // counters are sampled with the beat they leave with
      if (o_load) begin
        ohits_q <= (st_q == S_CLR) ? 32'd0 : hits_q;
        omiss_q <= (st_q == S_CLR) ? 32'd0 : miss_q;
      end
      case (st_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            act_q    <= action_e'(s_axis_tuser);
            sec_q    <= s_axis_tdata[SectorW-1:0];
            inv_ok_q <= 1'b0;
            if (s_axis_tuser == ACT_FLUSH) begin
              idx_q <= '0;
              st_q  <= S_FLUSH;
            end else if (s_axis_tuser == ACT_CLEAR) begin
              st_q <= S_CLR;
            end else if (s_axis_tdata[SectorW-1:0] >= img_q) begin
              st_q <= S_INV;
            end else begin
              fat_q <= (s_axis_tdata[SectorW-1:0] < fatlim_q);
              idx_q <= (s_axis_tdata[SectorW-1:0] < fatlim_q) ? CW'(0) : CW'(FAT_SLOTS);
              st_q  <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          logic          n_inv_ok;
          logic [CW-1:0] n_inv, n_vic;
          logic [AgeW-1:0] n_vage;
          n_inv_ok = inv_ok_q;
          n_inv    = inv_q;
          n_vic    = vic_q;
          n_vage   = vage_q;
          if (!cur.valid && !inv_ok_q) begin
            n_inv_ok = 1'b1;
            n_inv    = idx_q;
          end
          if (idx_q == lo || cur.age > vage_q) begin
            n_vic  = idx_q;
            n_vage = cur.age;
          end
          inv_ok_q <= n_inv_ok;
          inv_q    <= n_inv;
          vic_q    <= n_vic;
          vage_q   <= n_vage;
          if (cur.valid && cur.tag == start) begin
            hits_q <= hits_q + 32'd1;
            st_q   <= S_HIT;
          end else if (idx_q == last) begin
            miss_q <= miss_q + 32'd1;
            idx_q  <= n_inv_ok ? n_inv : n_vic;
            st_q   <= S_WB;
          end else begin
            idx_q <= idx_q + CW'(1);
          end
        end
        S_WB: begin
          if (!(cur.valid && cur.dirty)) begin
            st_q <= S_FILL;
          end else if (can_emit) begin
            okind_q <= KIND_WB; olast_q <= 1'b0;
            oreg_q <= fat_q; oslot_q <= slot32[2:0]; obs_q <= cur.tag;
            ooff_q <= '0; ocnt_q <= span(cur.tag, img_q); ohit_q <= 1'b0;
            st_q <= S_FILL;
          end
        end
        S_FILL: begin
          if (can_emit) begin
            okind_q <= KIND_FILL; olast_q <= 1'b0;
            oreg_q <= fat_q; oslot_q <= slot32[2:0]; obs_q <= start;
            ooff_q <= '0; ocnt_q <= span(start, img_q); ohit_q <= 1'b0;
            st_q <= S_GNT;
          end
        end
        S_HIT, S_GNT: begin
          if (can_emit) begin
            okind_q <= KIND_GRANT; olast_q <= 1'b1;
            oreg_q <= fat_q; oslot_q <= slot32[2:0]; obs_q <= start;
            ooff_q <= OffW'(sec_q - start); ocnt_q <= '0;
            ohit_q <= (st_q == S_HIT);
            st_q <= S_IDLE;
          end
        end
        S_FLUSH: begin
          if (!(cur.valid && cur.dirty) || can_emit) begin
            if (cur.valid && cur.dirty) begin
              okind_q <= KIND_WB; olast_q <= 1'b0;
              oreg_q  <= (32'(idx_q) < 32'(FAT_SLOTS));
              oslot_q <= (32'(idx_q) < 32'(FAT_SLOTS)) ? 3'(idx_q)
                         : 3'(32'(idx_q) - 32'(FAT_SLOTS));
              obs_q <= cur.tag; ooff_q <= '0;
              ocnt_q <= span(cur.tag, img_q); ohit_q <= 1'b0;
            end
            if (idx_q == CW'(NC - 1)) st_q <= S_CLR;
            else idx_q <= idx_q + CW'(1);
          end
        end
        S_CLR: begin
          if (can_emit) begin
            hits_q <= '0; miss_q <= '0;
            okind_q <= KIND_CLR; olast_q <= 1'b1;
            oreg_q <= 1'b0; oslot_q <= '0; obs_q <= '0;
            ooff_q <= '0; ocnt_q <= '0; ohit_q <= 1'b0;
            st_q <= S_IDLE;
          end
        end
        S_INV: begin
          if (can_emit) begin
            okind_q <= KIND_INV; olast_q <= 1'b1;
            oreg_q <= 1'b0; oslot_q <= '0; obs_q <= '0;
            ooff_q <= '0; ocnt_q <= '0; ohit_q <= 1'b0;
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {omiss_q, ohits_q, ohit_q, ocnt_q, ooff_q, obs_q, oslot_q, oreg_q};

  a_clr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_CLR |-> m_axis_tdata[87:24] == '0)
    else $error("clear beat carries nonzero counters");
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_GRANT || m_axis_tuser == KIND_INV
                      || m_axis_tuser == KIND_CLR) |-> m_axis_tlast)
    else $error("terminal beat without tlast");
  a_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_WB || m_axis_tuser == KIND_FILL)
    |-> !m_axis_tlast)
    else $error("write back or fill marked last");
  a_grant_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_GRANT |-> m_axis_tdata[22:19] == '0)
    else $error("grant with a sector count");
endmodule
`default_nettype wire

// ===== dv/tb_two_region_lru_sector_cache_unit.sv =====
// Self-checking testbench for the two-region LRU sector cache unit.
`timescale 1ns / 1ps
module tb_two_region_lru_sector_cache_unit;
  import srlc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 40;

  typedef struct packed {
    action_e            act;
    logic [SectorW-1:0] sector;
  } access_t;

  typedef struct packed {
    kind_e              kind;
    logic               region;
    logic [2:0]         slot;
    logic [SectorW-1:0] start;
    logic [OffW-1:0]    off;
    logic [CntW-1:0]    cnt;
    logic               hit;
    logic [31:0]        hits;
    logic [31:0]        misses;
    logic               last;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [SectorW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // sector, zero pad
  logic [1:0] s_axis_tuser = '0;   // action
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;  // region, slot, base, offset, count, hit, hits, misses
  logic [2:0] m_axis_tuser;   // kind
  logic m_axis_tlast;

  two_region_lru_sector_cache_unit u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always #2ns clk_i = ~clk_i;

  access_t access_q[$];
  outcome_t outcome_q[$];
  int mismatches = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit hold_start = 1'b0;
  int hold_left = 0;

  // cache shadow, region 1 = FAT
  logic [SectorW-1:0] tag_m[2][8];
  bit valid_m[2][8];
  bit dirty_m[2][8];
  int age_m[2][8];
  logic [31:0] hit_cnt, miss_cnt;
  int img_sectors = 2880;
  int fat_limit = 33;

  function automatic void clear_shadow();
    for (int r = 0; r < 2; r++) begin
      for (int s = 0; s < 8; s++) begin
        tag_m[r][s] = '0; valid_m[r][s] = 0; dirty_m[r][s] = 0; age_m[r][s] = 0;
      end
    end
    hit_cnt = '0;
    miss_cnt = '0;
  endfunction

  function automatic int clipped_span(int start);
    if (start >= img_sectors) return 0;
    return (img_sectors - start < BlockSectors) ? img_sectors - start : BlockSectors;
  endfunction

  function automatic void promote(int r, int s);
    int n;
    n = r ? 4 : 8;
    for (int j = 0; j < n; j++) begin
      if (j != s && valid_m[r][j])
        if ((!valid_m[r][s] || age_m[r][j] < age_m[r][s]) && age_m[r][j] < n - 1)
          age_m[r][j]++;
    end
    age_m[r][s] = 0;
  endfunction

  function automatic void post(kind_e k, int r, int s, int start, int off, int cnt, bit h);
    outcome_t o;
    o.kind = k; o.region = r[0]; o.slot = s[2:0]; o.start = start[SectorW-1:0];
    o.off = off[OffW-1:0]; o.cnt = cnt[CntW-1:0]; o.hit = h;
    o.hits = hit_cnt; o.misses = miss_cnt; o.last = 1'b0;
    outcome_q.push_back(o);
  endfunction

  function automatic void predict_lookup(access_t a);
    int r, n, start, sec, found, victim;
    sec = a.sector;
    if (a.act == ACT_FLUSH || a.act == ACT_CLEAR) begin
      if (a.act == ACT_FLUSH)
        for (int f = 1; f >= 0; f--)
          for (int s = 0; s < (f ? 4 : 8); s++)
            if (valid_m[f][s] && dirty_m[f][s])
              post(KIND_WB, f, s, tag_m[f][s], 0, clipped_span(tag_m[f][s]), 0);
      clear_shadow();
      post(KIND_CLR, 0, 0, 0, 0, 0, 0);
    end else if (sec >= img_sectors) begin
      post(KIND_INV, 0, 0, 0, 0, 0, 0);
    end else begin
      r = (sec < fat_limit) ? 1 : 0;
      n = r ? 4 : 8;
      start = (sec / BlockSectors) * BlockSectors;
      found = n;
      victim = n;
      for (int s = 0; s < n; s++)
        if (found == n && valid_m[r][s] && tag_m[r][s] == start) found = s;
      if (found < n) begin
        hit_cnt++;
        promote(r, found);
        if (a.act == ACT_WRITE) dirty_m[r][found] = 1;
        post(KIND_GRANT, r, found, start, sec - start, 0, 1);
      end else begin
        miss_cnt++;
        for (int s = 0; s < n; s++)
          if (victim == n && !valid_m[r][s]) victim = s;
        if (victim == n) begin
          victim = 0;
          for (int s = 1; s < n; s++)
            if (age_m[r][s] > age_m[r][victim]) victim = s;
        end
        if (valid_m[r][victim] && dirty_m[r][victim])
          post(KIND_WB, r, victim, tag_m[r][victim], 0, clipped_span(tag_m[r][victim]), 0);
        post(KIND_FILL, r, victim, start, 0, clipped_span(start), 0);
        promote(r, victim);
        tag_m[r][victim] = start[SectorW-1:0];
        valid_m[r][victim] = 1;
        dirty_m[r][victim] = (a.act == ACT_WRITE);
        post(KIND_GRANT, r, victim, start, sec - start, 0, 0);
      end
    end
    outcome_q[$].last = 1'b1;
  endfunction

  // sender
  int send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (s_axis_tvalid) begin
        predict_lookup(access_q[0]);
        access_q.pop_front();
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (access_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        send_gap <= $urandom_range(0, 11);
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, access_q[0].sector};
        s_axis_tuser <= access_q[0].act;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_start) hold_left <= 500;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // receiver and checker
  int recv_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {kind_e'(m_axis_tuser), m_axis_tdata[0], m_axis_tdata[3:1], m_axis_tdata[15:4],
               m_axis_tdata[18:16], m_axis_tdata[22:19], m_axis_tdata[23],
               m_axis_tdata[55:24], m_axis_tdata[87:56], m_axis_tlast};
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat: %p", got);
        end else begin
          if (got !== outcome_q[0]) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: exp %p got %p", outcome_q[0], got);
          end
          outcome_q.pop_front();
        end
      end
      if (hold_start || hold_left > 1) begin
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        recv_gap <= $urandom_range(0, 11);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("two_region_lru_sector_cache_unit regression: fail");
      $finish;
    end
  end

  task automatic wait_idle();
    while (access_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[SectorW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_IMAGE) img_sectors = value;
    else fat_limit = value;
  endtask

  task automatic queue_access(action_e act, int sector);
    access_t a;
    a.act = act;
    a.sector = sector[SectorW-1:0];
    access_q.push_back(a);
  endtask

  task automatic queue_random(int count);
    int r, sec;
    action_e act;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      act = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
      if (r < 35 && fat_limit > 0) sec = $urandom_range(0, fat_limit > 48 ? 47 : fat_limit - 1);
      else if (r < 78) sec = (fat_limit + $urandom_range(0, 95)) & 12'hfff;
      else if (r < 93) sec = $urandom_range(0, 4095);
      else if (r < 97) act = ACT_FLUSH;
      else act = ACT_CLEAR;
      if (act == ACT_FLUSH || act == ACT_CLEAR) sec = $urandom_range(0, 4095);
      queue_access(act, sec);
    end
  endtask

  initial begin
    clear_shadow();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: defaults, hits, dirty eviction, range edge, flush and clear
    @(negedge clk_i);
    queue_access(ACT_READ, 0);
    queue_access(ACT_WRITE, 5);
    queue_access(ACT_WRITE, 32);
    queue_access(ACT_READ, 4095);
    queue_access(ACT_READ, 2880);
    queue_access(ACT_WRITE, 2879);
    for (int b = 0; b < 9; b++) queue_access(ACT_WRITE, 40 + 8 * b + b % 8);
    queue_access(ACT_READ, 47);
    queue_access(ACT_WRITE, 8);
    queue_access(ACT_WRITE, 16);
    queue_access(ACT_WRITE, 24);
    queue_access(ACT_FLUSH, 4095);
    queue_access(ACT_WRITE, 100);
    queue_access(ACT_CLEAR, 0);
    queue_access(ACT_FLUSH, 0);
    wait_idle();

    // whole range as data, clipped fill at the image end
    write_reg(REG_IMAGE, 4095);
    write_reg(REG_FAT, 0);
    @(negedge clk_i);
    queue_access(ACT_WRITE, 4088);
    queue_access(ACT_READ, 4094);
    queue_random(50);
    @(posedge clk_i);
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    wait_idle();

    // shrink the image under dirty blocks, then flush
    @(negedge clk_i);
    queue_access(ACT_WRITE, 3000);
    queue_access(ACT_WRITE, 97);
    wait_idle();
    write_reg(REG_IMAGE, 100);
    @(negedge clk_i);
    queue_access(ACT_FLUSH, 0);
    wait_idle();

    // empty image, every access out of range
    write_reg(REG_IMAGE, 0);
    write_reg(REG_FAT, 4095);
    @(negedge clk_i);
    queue_access(ACT_READ, 0);
    queue_access(ACT_WRITE, 4095);
    wait_idle();

    // all sectors in the FAT region
    write_reg(REG_IMAGE, 2883);
    @(negedge clk_i);
    queue_random(40);
    wait_idle();

    // defaults again, no idling to the end
    write_reg(REG_IMAGE, 2880);
    write_reg(REG_FAT, 33);
    @(negedge clk_i);
    queue_random(30);
    wait_idle();
    calm = 1'b1;
    @(negedge clk_i);
    queue_random(30);
    wait_idle();

    if (mismatches == 0 && outcome_q.size() == 0)
      $display("two_region_lru_sector_cache_unit regression: pass");
    else
      $display("two_region_lru_sector_cache_unit regression: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/srlc_pkg.sv
hw/rtl/srlc_cell.sv
hw/rtl/two_region_lru_sector_cache_unit.sv
dv/tb_two_region_lru_sector_cache_unit.sv
